[sv/scl2x_pkg.sv]
// shared types, constants and helpers for the scale2x upscaler
`timescale 1ns / 1ps
package scl2x_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_PIXEL_BITS = 32;

   localparam int PIX_OUT_W   = 32;
   localparam int BLOCK_COL_W = 10;
   localparam int BLOCK_ROW_W = 12;

   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_FIELDS_W  = 4 * PIX_OUT_W + BLOCK_COL_W + BLOCK_ROW_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;

   localparam int CSR_WIDTH_W  = 11;
   localparam int CSR_HEIGHT_W = 13;
   localparam int CSR_DEPTH_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_DEPTH_MODE   = 2'd2
   } csr_index_type;

   typedef enum logic [CSR_DEPTH_W-1:0] {
      DEPTH_8  = 2'd0,
      DEPTH_16 = 2'd1,
      DEPTH_24 = 2'd2,
      DEPTH_32 = 2'd3
   } depth_type;

   typedef struct packed {
      logic [PIX_OUT_W-1:0] top_left;
      logic [PIX_OUT_W-1:0] top_right;
      logic [PIX_OUT_W-1:0] bottom_left;
      logic [PIX_OUT_W-1:0] bottom_right;
   } block_type;

   typedef struct packed {
      block_type              pix;
      logic [BLOCK_COL_W-1:0] col;
      logic [BLOCK_ROW_W-1:0] row;
      logic                   frame_end;
   } result_type;

   function automatic logic [PIX_OUT_W-1:0] depth_mask(input depth_type depth);
      logic [PIX_OUT_W-1:0] m;
      case (depth)
         DEPTH_8:  m = 32'h0000_00FF;
         DEPTH_16: m = 32'h0000_FFFF;
         DEPTH_24: m = 32'h00FF_FFFF;
         DEPTH_32: m = 32'hFFFF_FFFF;
         default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

[sv/scl2x_line_store.sv]
// one row of pixels: single write port, single registered read port
`timescale 1ns / 1ps
module scl2x_line_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the contents from before a write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/scl2x_rule.sv]
// scale2x rule for one 2x2 output block, compares on the masked pixel bits
`timescale 1ns / 1ps
module scl2x_rule #(
   parameter int PIXEL_BITS = 32
) (
   input  logic [PIXEL_BITS-1:0] mask,
   input  logic [PIXEL_BITS-1:0] pix_b,
   input  logic [PIXEL_BITS-1:0] pix_d,
   input  logic [PIXEL_BITS-1:0] pix_e,
   input  logic [PIXEL_BITS-1:0] pix_f,
   input  logic [PIXEL_BITS-1:0] pix_h,
   output scl2x_pkg::block_type  blk
);
   import scl2x_pkg::*;

   logic [PIXEL_BITS-1:0] b, d, e, f, h;
   logic                  db, bf, dh, hf;

   always_comb begin
      b = pix_b & mask;
      d = pix_d & mask;
      e = pix_e & mask;
      f = pix_f & mask;
      h = pix_h & mask;
      db = (d == b);
      bf = (b == f);
      dh = (d == h);
      hf = (h == f);
      blk.top_left     = PIX_OUT_W'((db && !bf && !dh) ? d : e);
      blk.top_right    = PIX_OUT_W'((bf && !db && !hf) ? f : e);
      blk.bottom_left  = PIX_OUT_W'((dh && !db && !hf) ? d : e);
      blk.bottom_right = PIX_OUT_W'((hf && !dh && !bf) ? f : e);
   end

endmodule

[sv/scl2x_result_buf.sv]
// result register: holds up to three blocks of one request and hands them out in order
`timescale 1ns / 1ps
module scl2x_result_buf (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [2:0]                            load_en,
   input  scl2x_pkg::result_type [2:0]           load_items,
   output logic                                  free,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tl[31:0], tr[63:32], bl[95:64], br[127:96], col[137:128], row[149:138], zero pad
   output logic [scl2x_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   // frame_end
   output logic                                  rsp_tuser
);
   import scl2x_pkg::*;

   result_type [2:0] items_ff;
   logic [2:0]       pend_ff, pend_in;
   logic [1:0]       slot;
   logic [2:0]       slot_bit;
   logic             take, last_one;
   result_type       cur;

   always_comb begin
      if (pend_ff[0]) begin
         slot = 2'd0;
      end else if (pend_ff[1]) begin
         slot = 2'd1;
      end else begin
         slot = 2'd2;
      end
      slot_bit   = 3'd1 << slot;
      cur        = items_ff[slot];
      rsp_tvalid = (pend_ff != 3'd0);
      take       = rsp_tvalid && rsp_tready;
      last_one   = rsp_tvalid && ((pend_ff & (pend_ff - 3'd1)) == 3'd0);
      free       = !rsp_tvalid || (take && last_one);
      if (load) begin
         pend_in = load_en;
      end else if (take) begin
         pend_in = pend_ff & ~slot_bit;
      end else begin
         pend_in = pend_ff;
      end
      rsp_tdata = {{RSP_PAD_W{1'b0}}, cur.row, cur.col, cur.pix.bottom_right,
                   cur.pix.bottom_left, cur.pix.top_right, cur.pix.top_left};
      rsp_tlast = last_one;
      rsp_tuser = cur.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= load_items;
      end
   end

endmodule

[sv/scale2x_pixel_upscaler.sv]
// Scale2x 2x upscaler: source pixels in raster order in, one 2x2 block per source pixel out.
// Rows of source pixels enter one request per clock while the result register is free; the
// block of row y leaves as row y+1 comes in, at the same column, so a frame needs one full
// row in flight. On the last row each request yields up to two blocks (its own row's block
// trails one pixel behind), and the final pixel of the frame up to three, so the last row
// is slowed by the single result port. Each request waits in the input register, where
// the two line stores are read, then moves into the result register; a new request is
// taken in the same cycle the previous one moves on. Compares use only the low 8/16/24/32
// bits chosen by depth_mode. Writing image_width or image_height restarts the frame;
// configuration is to be written only while no request is in flight.
`timescale 1ns / 1ps
module scale2x_pixel_upscaler #(
   parameter int MAX_WIDTH  = scl2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = scl2x_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = scl2x_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // src_pixel[31:0]
   input  logic [scl2x_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_top_left[31:0], out_top_right[63:32], out_bottom_left[95:64],
   // out_bottom_right[127:96], block_col[137:128], block_row[149:138], zero pad
   output logic [scl2x_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   // frame_end
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [scl2x_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scl2x_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scl2x_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int EW_W  = (WID_W > CSR_WIDTH_W) ? WID_W : CSR_WIDTH_W;
   localparam int EH_W  = (HGT_W > CSR_HEIGHT_W) ? HGT_W : CSR_HEIGHT_W;

   // configuration
   logic [CSR_WIDTH_W-1:0]  width_ff;
   logic [CSR_HEIGHT_W-1:0] height_ff;
   depth_type               depth_ff;

   // frame position of the next request
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             sel_ff, sel_in;
   logic [PIXEL_BITS-1:0] line_first_ff;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_px_ff;
   logic [PIXEL_BITS-1:0] s1_prev0_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic                  s1_sel_ff;
   logic                  s1_first_ff, s1_second_ff, s1_last_col_ff, s1_last_row_ff;
   logic                  s1_r_ge1_ff, s1_r_ge2_ff;

   // sliding window over the previous row and history of the current row
   logic [PIXEL_BITS-1:0] win_left_ff, win_mid_ff;
   logic [PIXEL_BITS-1:0] hist1_ff, hist2_ff;

   logic [EW_W-1:0]       wid_ext, eff_w;
   logic [EH_W-1:0]       hgt_ext, eff_h;
   logic [COL_W-1:0]      last_col, cur_col, next_col;
   logic                  last_row;
   logic                  accept, s1_adv, s2_free;
   logic                  restart;
   logic [PIXEL_BITS-1:0] px;
   logic [COL_W-1:0]      rd_addr_a, rd_addr_b;
   logic [PIXEL_BITS-1:0] rd_data_a, rd_data_b;

   logic [PIXEL_BITS-1:0] mask, old_px, prev_next, mid, left, cur_m2;
   block_type             blk0, blk1, blk2;
   result_type [2:0]      items;
   logic [2:0]            item_en;

   // frame geometry
   always_comb begin
      wid_ext = EW_W'(width_ff);
      hgt_ext = EH_W'(height_ff);
      if (wid_ext == EW_W'(0)) begin
         eff_w = EW_W'(1);
      end else if (wid_ext > EW_W'(MAX_WIDTH)) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = wid_ext;
      end
      if (hgt_ext == EH_W'(0)) begin
         eff_h = EH_W'(1);
      end else if (hgt_ext > EH_W'(MAX_HEIGHT)) begin
         eff_h = EH_W'(MAX_HEIGHT);
      end else begin
         eff_h = hgt_ext;
      end
      last_col = COL_W'(eff_w - EW_W'(1));
      cur_col  = (col_ff > last_col) ? last_col : col_ff;
      next_col = (cur_col == last_col) ? last_col : cur_col + COL_W'(1);
      last_row = (EH_W'(row_ff) + EH_W'(1)) >= eff_h;
   end

   // handshake
   always_comb begin
      px          = req_tdata[PIXEL_BITS-1:0];
      s1_adv      = s1_valid_ff && s2_free;
      req_tready  = !s1_valid_ff || s2_free;
      accept      = req_tvalid && req_tready;
      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
   end

   // position counters advance per accepted request; a size write restarts the frame
   always_comb begin
      restart = csr_we && (csr_index inside {CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT});
      col_in  = col_ff;
      row_in  = row_ff;
      sel_in  = sel_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         sel_in = 1'b0;
      end else if (accept) begin
         if (cur_col >= last_col) begin
            col_in = '0;
            sel_in = !sel_ff;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = cur_col + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CSR_WIDTH_W'(1);
         height_ff   <= CSR_HEIGHT_W'(1);
         depth_ff    <= DEPTH_32;
         col_ff      <= '0;
         row_ff      <= '0;
         sel_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         sel_ff      <= sel_in;
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata[CSR_WIDTH_W-1:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata[CSR_HEIGHT_W-1:0];
               end
               CSR_DEPTH_MODE: begin
                  depth_ff <= depth_type'(csr_wdata[CSR_DEPTH_W-1:0]);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // the store selected by sel takes the arriving row; the other holds the row above
   always_comb begin
      rd_addr_a = sel_ff ? next_col : cur_col;
      rd_addr_b = sel_ff ? cur_col : next_col;
   end

   scl2x_line_store #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIXEL_BITS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (accept && !sel_ff),
      .wr_addr (cur_col),
      .wr_data (px),
      .rd_en   (accept),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   scl2x_line_store #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIXEL_BITS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (accept && sel_ff),
      .wr_addr (cur_col),
      .wr_data (px),
      .rd_en   (accept),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= px;
         s1_prev0_ff    <= line_first_ff;
         s1_col_ff      <= cur_col;
         s1_row_ff      <= row_ff;
         s1_sel_ff      <= sel_ff;
         s1_first_ff    <= (cur_col == '0);
         s1_second_ff   <= (cur_col == COL_W'(1));
         s1_last_col_ff <= (cur_col == last_col);
         s1_last_row_ff <= last_row;
         s1_r_ge1_ff    <= (row_ff != '0);
         s1_r_ge2_ff    <= (row_ff > ROW_W'(1));
         if (cur_col == '0) begin
            line_first_ff <= px;
         end
      end
      if (s1_adv) begin
         win_left_ff <= mid;
         win_mid_ff  <= prev_next;
         hist1_ff    <= s1_px_ff;
         hist2_ff    <= hist1_ff;
      end
   end

   // neighbors of the request in the input register
   always_comb begin
      mask      = PIXEL_BITS'(depth_mask(depth_ff));
      old_px    = s1_sel_ff ? rd_data_b : rd_data_a;
      prev_next = s1_sel_ff ? rd_data_a : rd_data_b;
      mid       = s1_first_ff ? s1_prev0_ff : win_mid_ff;
      left      = s1_first_ff ? s1_prev0_ff : win_left_ff;
      cur_m2    = s1_second_ff ? hist1_ff : hist2_ff;
   end

   // block of the row above, at this column
   scl2x_rule #(.PIXEL_BITS (PIXEL_BITS)) u_rule_above (
      .mask  (mask),
      .pix_b (s1_r_ge2_ff ? old_px : mid),
      .pix_d (left),
      .pix_e (mid),
      .pix_f (prev_next),
      .pix_h (s1_px_ff),
      .blk   (blk0)
   );

   // last row: block of the column to the left
   scl2x_rule #(.PIXEL_BITS (PIXEL_BITS)) u_rule_left (
      .mask  (mask),
      .pix_b (s1_r_ge1_ff ? left : hist1_ff),
      .pix_d (cur_m2),
      .pix_e (hist1_ff),
      .pix_f (s1_px_ff),
      .pix_h (hist1_ff),
      .blk   (blk1)
   );

   // last row, last column: this pixel's own block
   scl2x_rule #(.PIXEL_BITS (PIXEL_BITS)) u_rule_own (
      .mask  (mask),
      .pix_b (s1_r_ge1_ff ? mid : s1_px_ff),
      .pix_d (s1_first_ff ? s1_px_ff : hist1_ff),
      .pix_e (s1_px_ff),
      .pix_f (s1_px_ff),
      .pix_h (s1_px_ff),
      .blk   (blk2)
   );

   always_comb begin
      item_en[0] = s1_r_ge1_ff;
      item_en[1] = s1_last_row_ff && !s1_first_ff;
      item_en[2] = s1_last_row_ff && s1_last_col_ff;

      items[0].pix       = blk0;
      items[0].col       = BLOCK_COL_W'(s1_col_ff);
      items[0].row       = BLOCK_ROW_W'(s1_row_ff - ROW_W'(1));
      items[0].frame_end = 1'b0;

      items[1].pix       = blk1;
      items[1].col       = BLOCK_COL_W'(s1_col_ff - COL_W'(1));
      items[1].row       = BLOCK_ROW_W'(s1_row_ff);
      items[1].frame_end = 1'b0;

      items[2].pix       = blk2;
      items[2].col       = BLOCK_COL_W'(s1_col_ff);
      items[2].row       = BLOCK_ROW_W'(s1_row_ff);
      items[2].frame_end = 1'b1;
   end

   scl2x_result_buf u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_adv),
      .load_en    (item_en),
      .load_items (items),
      .free       (s2_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[dv/scale2x_block_checker.sv]
// checker for the scale2x upscaler: predicts every 2x2 block and compares the result stream
`timescale 1ns / 1ps
module scale2x_block_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [scl2x_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [scl2x_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [scl2x_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scl2x_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  mismatch_count,
   output int                                  blocks_owed
);
   import scl2x_pkg::*;

   localparam int COL_LSB    = 4 * PIX_OUT_W;
   localparam int ROW_LSB    = COL_LSB + BLOCK_COL_W;
   localparam int REPORT_CAP = 200;

   typedef struct packed {
      logic [PIX_OUT_W-1:0]   top_left;
      logic [PIX_OUT_W-1:0]   top_right;
      logic [PIX_OUT_W-1:0]   bottom_left;
      logic [PIX_OUT_W-1:0]   bottom_right;
      logic [BLOCK_COL_W-1:0] col;
      logic [BLOCK_ROW_W-1:0] row;
      logic                   run_last;
      logic                   frame_end;
   } upscaled_block_type;

   upscaled_block_type owed_blocks[$];

   // two line stores: line_mem[store_sel] takes the arriving row, the other holds the row above
   logic [PIX_OUT_W-1:0]    line_mem [2][DEF_MAX_WIDTH];
   logic                    store_sel;
   int                      col_pos;
   int                      row_pos;
   logic [CSR_WIDTH_W-1:0]  width_reg;
   logic [CSR_HEIGHT_W-1:0] height_reg;
   depth_type               depth_reg;

   function automatic upscaled_block_type scale_rule(input logic [31:0] b, input logic [31:0] d,
                                                     input logic [31:0] e, input logic [31:0] f,
                                                     input logic [31:0] h, input int col,
                                                     input int row, input logic fend);
      upscaled_block_type blk;
      logic [31:0]        m;
      m = 32'hFFFF_FFFF >> (8 * (3 - int'(depth_reg)));
      b &= m;
      d &= m;
      e &= m;
      f &= m;
      h &= m;
      blk.top_left     = (d == b && b != f && d != h) ? d : e;
      blk.top_right    = (b == f && b != d && f != h) ? f : e;
      blk.bottom_left  = (d == h && d != b && h != f) ? d : e;
      blk.bottom_right = (h == f && d != h && b != f) ? f : e;
      blk.col          = BLOCK_COL_W'(col);
      blk.row          = BLOCK_ROW_W'(row);
      blk.run_last     = 1'b0;
      blk.frame_end    = fend;
      return blk;
   endfunction

   // block of the last row itself, built from the row now arriving
   function automatic upscaled_block_type last_row_block(input int k, input int r,
                                                         input int lastc);
      logic [31:0] e;
      e = line_mem[store_sel][k];
      return scale_rule((r >= 1) ? line_mem[~store_sel][k] : e,
                        line_mem[store_sel][(k > 0) ? k - 1 : 0], e,
                        line_mem[store_sel][(k < lastc) ? k + 1 : lastc], e, k, r, k == lastc);
   endfunction

   function automatic void absorb_pixel(input logic [31:0] px);
      int                 w;
      int                 h;
      int                 c;
      int                 r;
      int                 lastc;
      int                 n;
      int                 i;
      logic               on_last_row;
      logic [31:0]        old_px;
      logic [31:0]        above;
      upscaled_block_type made [3];
      w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
      c = col_pos;
      r = row_pos;
      lastc = w - 1;
      on_last_row = (r + 1 >= h);
      n = 0;
      if (c > lastc) c = lastc;
      old_px = line_mem[store_sel][c];
      line_mem[store_sel][c] = px;
      if (r >= 1) begin
         // the entry being overwritten is two rows up, which is B from row 2 on
         above = (r >= 2) ? old_px : line_mem[~store_sel][c];
         made[n] = scale_rule(above, line_mem[~store_sel][(c > 0) ? c - 1 : 0],
                              line_mem[~store_sel][c],
                              line_mem[~store_sel][(c < lastc) ? c + 1 : lastc],
                              px, c, r - 1, 1'b0);
         n++;
      end
      if (on_last_row && c >= 1) begin
         made[n] = last_row_block(c - 1, r, lastc);
         n++;
      end
      if (on_last_row && c == lastc) begin
         made[n] = last_row_block(c, r, lastc);
         n++;
      end
      if (n > 0) made[n-1].run_last = 1'b1;
      for (i = 0; i < n; i++) owed_blocks.push_back(made[i]);
      if (c >= lastc) begin
         col_pos = 0;
         store_sel = ~store_sel;
         row_pos = on_last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = val[CSR_WIDTH_W-1:0];
            col_pos = 0;
            row_pos = 0;
            store_sel = 1'b0;
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = val[CSR_HEIGHT_W-1:0];
            col_pos = 0;
            row_pos = 0;
            store_sel = 1'b0;
         end
         CSR_DEPTH_MODE: begin
            depth_reg = depth_type'(val[CSR_DEPTH_W-1:0]);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_block();
      upscaled_block_type want;
      upscaled_block_type got;
      got.top_left     = rsp_tdata[0 +: PIX_OUT_W];
      got.top_right    = rsp_tdata[PIX_OUT_W +: PIX_OUT_W];
      got.bottom_left  = rsp_tdata[2 * PIX_OUT_W +: PIX_OUT_W];
      got.bottom_right = rsp_tdata[3 * PIX_OUT_W +: PIX_OUT_W];
      got.col          = rsp_tdata[COL_LSB +: BLOCK_COL_W];
      got.row          = rsp_tdata[ROW_LSB +: BLOCK_ROW_W];
      got.run_last     = rsp_tlast;
      got.frame_end    = rsp_tuser;
      if (owed_blocks.size() == 0) begin
         if (mismatch_count < REPORT_CAP)
            $display("%0t: unrequested block, expected none got %h", $time, got);
         mismatch_count++;
      end else begin
         want = owed_blocks.pop_front();
         compare_field("top_left", want.top_left, got.top_left);
         compare_field("top_right", want.top_right, got.top_right);
         compare_field("bottom_left", want.bottom_left, got.bottom_left);
         compare_field("bottom_right", want.bottom_right, got.bottom_right);
         compare_field("block_col", 32'(want.col), 32'(got.col));
         compare_field("block_row", 32'(want.row), 32'(got.row));
         compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
         compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
         compare_field("pad", 32'd0, 32'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         store_sel = 1'b0;
         col_pos = 0;
         row_pos = 0;
         width_reg = CSR_WIDTH_W'(1);
         height_reg = CSR_HEIGHT_W'(1);
         depth_reg = DEPTH_32;
         owed_blocks.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         // older blocks are checked before this edge's request adds new ones
         if (rsp_tvalid && rsp_tready) check_block();
         if (req_tvalid && req_tready) absorb_pixel(req_tdata);
      end
      blocks_owed <= owed_blocks.size();
   end

endmodule

[dv/tb.sv]
// testbench top for the scale2x upscaler: clock, reset, pixel and csr stimulus, verdict
`timescale 1ns / 1ps
module tb;
   import scl2x_pkg::*;

   localparam int RANDOM_ITEMS = 206;
   localparam int WIDE_ITEMS   = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT  = 3000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int          mismatch_count;
   int          blocks_owed;
   int          idle_cycles = 0;
   int          sent_total = 0;
   int          burst_left = 1;
   int          frame_w = 1;
   int          frame_h = 1;
   depth_type   cur_depth = DEPTH_32;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   logic [31:0] palette [4];

   scale2x_pixel_upscaler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scale2x_block_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .blocks_owed    (blocks_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random ready odds that change every so often, plus one long hold-off
   initial begin
      int ready_pct;
      int span;
      span = 0;
      ready_pct = 100;
      wait (reset == 1'b0);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (span == 0) begin
               ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(15, 95);
               span = $urandom_range(20, 120);
            end
            span--;
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
            @(posedge clock);
         end
      end
   end

   function automatic int clamp_dim(input int val, input int bits, input int limit);
      int v;
      v = val & ((1 << bits) - 1);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   // colors that match only under the depth mask show up often, so the rule fires
   task automatic fresh_palette();
      logic [31:0] hidden;
      hidden = ~(32'hFFFF_FFFF >> (8 * (3 - int'(cur_depth))));
      palette[0] = $urandom();
      palette[1] = palette[0] ^ ($urandom() & hidden);
      palette[2] = $urandom();
      palette[3] = ($urandom_range(0, 1) == 1) ? palette[2] ^ ($urandom() & hidden) : $urandom();
   endtask

   function automatic logic [31:0] next_pixel();
      if ($urandom_range(0, 6) == 0) return $urandom();
      return palette[$urandom_range(0, 3)];
   endfunction

   task automatic push_pixel(input logic [31:0] px);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_total++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_run(input int count);
      repeat (count) push_pixel(next_pixel());
   endtask

   // wait for every owed block, then let the pipeline empty of requests with no result
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blocks_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // a negative value leaves that register alone
   task automatic configure(input int width_val, input int height_val, input int depth_val);
      if (width_val >= 0) begin
         write_reg(CSR_IMAGE_WIDTH, width_val);
         frame_w = clamp_dim(width_val, CSR_WIDTH_W, DEF_MAX_WIDTH);
      end
      if (height_val >= 0) begin
         write_reg(CSR_IMAGE_HEIGHT, height_val);
         frame_h = clamp_dim(height_val, CSR_HEIGHT_W, DEF_MAX_HEIGHT);
      end
      if (depth_val >= 0) begin
         write_reg(CSR_DEPTH_MODE, depth_val);
         cur_depth = depth_type'(depth_val);
      end
   endtask

   initial begin
      int w;
      int h;
      int roll;
      int area;
      int count;
      int random_goal;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values: 1x1 frames, so each pixel is a whole frame
      push_pixel(32'h0000_0000);
      push_pixel(32'hFFFF_FFFF);

      // zero width acts as one: single column
      settle();
      configure(0, 3, DEPTH_8);
      fresh_palette();
      send_run(3);

      // zero height acts as one: single row
      settle();
      configure(4, 0, DEPTH_16);
      fresh_palette();
      send_run(4);

      // depth change mid-frame, then width and height restarts mid-frame
      settle();
      configure(3, 2, DEPTH_24);
      fresh_palette();
      send_run(4);
      settle();
      configure(-1, -1, DEPTH_32);
      send_run(4);
      settle();
      configure(2, -1, -1);
      send_run(2);
      settle();
      write_reg(CSR_SPARE, $urandom());
      configure(-1, 2, -1);
      send_run(4);

      // widest row: every wdata bit set, width clamps to the maximum; only its start is sent
      settle();
      configure((1 << CSR_DATA_W) - 1, 1, DEPTH_32);
      fresh_palette();
      send_run(WIDE_ITEMS);

      // tallest frame: height clamps, only the first rows are sent
      settle();
      configure(5, (1 << CSR_DATA_W) - 1, DEPTH_16);
      fresh_palette();
      send_run(17);

      random_goal = sent_total + RANDOM_ITEMS;

      // long receiver hold-off while the sender keeps offering a full frame
      settle();
      configure(8, 8, $urandom_range(0, 3));
      fresh_palette();
      hold_req = 1'b1;
      send_run(frame_w * frame_h);

      while (sent_total < random_goal) begin
         settle();
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            // depth only: the frame goes on where it stands
            configure(-1, -1, $urandom_range(0, 3));
            fresh_palette();
            count = $urandom_range(1, 30);
         end else begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 9);
            h = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 6);
            configure(w, h, $urandom_range(0, 3));
            fresh_palette();
            area = frame_w * frame_h;
            if (area > 80)
               count = $urandom_range(1, 40);
            else if (roll < 35)
               count = $urandom_range(1, area);
            else
               count = area * $urandom_range(1, 3);
         end
         if (count > random_goal - sent_total)
            count = random_goal - sent_total;
         send_run(count);
      end

      settle();
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
